FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands clocked on i_clk, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold on every clock edge out of reset
`define OAM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) else $error(msg);

// antecedent on one edge implies consequent on the next edge
`define OAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/oam_pkg.sv
// ----------------------------------------------------------------------------
// oam_pkg
// Shared widths, reset values, orientation codes and offset table for the
// orientation-corrected accelerometer averaging filter.
// ----------------------------------------------------------------------------
package oam_pkg;

    // axis count and sample format
    localparam int AXES     = 3;
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 15;
    localparam int MAG_W    = 32;

    // window depth is a power of two; mean is a shift with sign correction
    localparam int WIN_LOG2  = 3;
    localparam int WIN_DEPTH = 1 << WIN_LOG2;
    localparam int SUM_W     = SAMPLE_W + WIN_LOG2;

    // stream payload widths (bytes padded)
    localparam int IN_W  = ((AXES * SAMPLE_W + 7) / 8) * 8;
    localparam int OUT_W = ((AXES * SAMPLE_W + MAG_W + 7) / 8) * 8;

    // reset values
    localparam logic [THR_W-1:0]           THR_RESET = THR_W'(16000);
    localparam logic signed [SAMPLE_W-1:0] WIN_RESET = SAMPLE_W'(9310);
    localparam logic signed [SUM_W-1:0]    SUM_RESET = SUM_W'(WIN_DEPTH * 9310);

    // orientation codes
    localparam logic [2:0] ORI_NONE = 3'd0;
    localparam logic [2:0] ORI_XPOS = 3'd1;
    localparam logic [2:0] ORI_XNEG = 3'd2;
    localparam logic [2:0] ORI_YPOS = 3'd3;
    localparam logic [2:0] ORI_YNEG = 3'd4;
    localparam logic [2:0] ORI_ZPOS = 3'd5;

    // one sample per axis, index 0 = x
    typedef logic [AXES-1:0][SAMPLE_W-1:0] t_axes;

    // updated window sums handed to the averaging pipeline
    typedef struct packed {
        logic                         valid;
        logic [AXES-1:0][SUM_W-1:0]   sum;
    } t_sum_req;

    // finished result
    typedef struct packed {
        logic                         valid;
        logic [AXES-1:0][SAMPLE_W-1:0] mean;
        logic [MAG_W-1:0]             mag;
    } t_result;

    // per-orientation axis offsets
    function automatic t_axes orient_offsets(input logic [2:0] ori);
        t_axes off;
        off = '0;
        unique case (ori)
            ORI_XPOS: begin
                off[0] = SAMPLE_W'(100);
                off[1] = SAMPLE_W'(-70);
                off[2] = SAMPLE_W'(-500);
            end
            ORI_XNEG: begin
                off[0] = SAMPLE_W'(100);
                off[2] = SAMPLE_W'(300);
            end
            ORI_YPOS: begin
                off[0] = SAMPLE_W'(500);
                off[1] = SAMPLE_W'(-200);
                off[2] = SAMPLE_W'(600);
            end
            ORI_YNEG: begin
                off[0] = SAMPLE_W'(-65);
                off[2] = SAMPLE_W'(-225);
            end
            ORI_ZPOS: begin
                off[0] = SAMPLE_W'(150);
                off[1] = SAMPLE_W'(-110);
            end
            default: begin
                off = '0;
            end
        endcase
        return off;
    endfunction

endpackage

FILE: rtl/core/accel_offset_average_magnitude.sv
// ----------------------------------------------------------------------------
// accel_offset_average_magnitude
// Orientation-corrected boxcar filter for three-axis accelerometer samples,
// with the squared magnitude of the filtered vector.
//
//   channel   dir  handshake                      payload
//   s_axis    in   i_s_axis_tvalid/o_s_axis_tready  accel x, y, z
//   m_axis    out  o_m_axis_tvalid/i_m_axis_tready  means x, y, z, magnitude^2
//   cfg       in   i_cfg_valid/o_cfg_ready          orientation threshold
//
// One sample per cycle while the output accepts; each passes the input register, then oam_mag stages a, b and c.
// The window sums are updated when an item leaves the input register, so
// consecutive items never wait on each other.
// Synchronous active-low reset: windows hold 9310, position 0, threshold 16000.
// A stalled output fills the pipeline bubbles first; input backs up only
// when all four stages hold a request.
// ----------------------------------------------------------------------------
module accel_offset_average_magnitude (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [oam_pkg::IN_W-1:0]      i_s_axis_tdata,  // accel_x, accel_y, accel_z
    // master stream
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [oam_pkg::OUT_W-1:0]     o_m_axis_tdata,  // filtered_x, _y, _z, magnitude_sq
    // configuration write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [oam_pkg::THR_W-1:0]     i_cfg_data       // tilt_limit
);
    import oam_pkg::*;

    logic               r_s0_valid;
    t_axes              r_s0_acc;
    logic [THR_W-1:0]   r_thr;

    t_axes              w_corr;
    t_sum_req           w_req;
    logic [AXES-1:0][SUM_W-1:0] w_sum;
    logic               w_req_ready;
    logic               w_s0_adv;
    t_result            w_res;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= THR_RESET;
        end else if (i_cfg_valid) begin
            r_thr <= i_cfg_data;
        end
    end

    // input register
    assign w_s0_adv        = r_s0_valid && w_req_ready;
    assign o_s_axis_tready = !r_s0_valid || w_req_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_s0_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_s0_acc <= i_s_axis_tdata[AXES*SAMPLE_W-1:0];
        end
    end

    // orientation offsets
    oam_orient u_orient (
        .i_acc (r_s0_acc),
        .i_thr (r_thr),
        .o_acc (w_corr)
    );

    // one window per axis, sums bundled with the input valid
    assign w_req = {r_s0_valid, w_sum};

    for (genvar g = 0; g < AXES; g++) begin : g_win
        oam_window u_win (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (w_s0_adv),
            .i_sample   (w_corr[g]),
            .o_sum_next (w_sum[g])
        );
    end

    // means and magnitude
    oam_mag u_mag (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_req_ready (w_req_ready),
        .o_res       (w_res),
        .i_res_ready (i_m_axis_tready)
    );

    assign o_m_axis_tvalid = w_res.valid;
    assign o_m_axis_tdata  = OUT_W'({w_res.mag, w_res.mean});

    // checks
`include "assert_macros.svh"

    `OAM_ASSERT_ALWAYS(a_empty_input_ready, r_s0_valid || o_s_axis_tready, "empty input stage not ready")
    `OAM_ASSERT_NEXT(a_accept_loads, i_s_axis_tvalid && o_s_axis_tready, r_s0_valid, "accepted request lost")
    `OAM_ASSERT_ALWAYS(a_zero_mag, !o_m_axis_tvalid || (o_m_axis_tdata[47:0] != 48'd0) || (o_m_axis_tdata[79:48] == 32'd0), "nonzero magnitude for zero means")

endmodule

FILE: rtl/core/oam_orient.sv
// ----------------------------------------------------------------------------
// oam_orient
// Picks the dominant orientation by priority and adds its axis offsets
// with 16-bit wraparound.
// ----------------------------------------------------------------------------
module oam_orient (
    input  oam_pkg::t_axes                   i_acc,
    input  logic [oam_pkg::THR_W-1:0]        i_thr,
    output oam_pkg::t_axes                   o_acc
);
    import oam_pkg::*;

    logic signed [SAMPLE_W:0] w_ax;
    logic signed [SAMPLE_W:0] w_ay;
    logic signed [SAMPLE_W:0] w_az;
    logic signed [SAMPLE_W:0] w_thr_p;
    logic signed [SAMPLE_W:0] w_thr_n;
    logic [2:0]               w_ori;
    t_axes                    w_off;

    // widen to 17 bits so -threshold and the samples compare exactly
    assign w_ax    = $signed({i_acc[0][SAMPLE_W-1], i_acc[0]});
    assign w_ay    = $signed({i_acc[1][SAMPLE_W-1], i_acc[1]});
    assign w_az    = $signed({i_acc[2][SAMPLE_W-1], i_acc[2]});
    assign w_thr_p = $signed({{(SAMPLE_W + 1 - THR_W){1'b0}}, i_thr});
    assign w_thr_n = -w_thr_p;

    // priority select, strict compares
    always_comb begin
        if (w_ax > w_thr_p) begin
            w_ori = ORI_XPOS;
        end else if (w_ax < w_thr_n) begin
            w_ori = ORI_XNEG;
        end else if (w_ay > w_thr_p) begin
            w_ori = ORI_YPOS;
        end else if (w_ay < w_thr_n) begin
            w_ori = ORI_YNEG;
        end else if (w_az > w_thr_p) begin
            w_ori = ORI_ZPOS;
        end else begin
            w_ori = ORI_NONE;
        end
    end

    assign w_off = orient_offsets(w_ori);

    // wrapping offset add
    always_comb begin
        for (int i = 0; i < AXES; i++) begin
            o_acc[i] = i_acc[i] + w_off[i];
        end
    end

endmodule

FILE: rtl/core/oam_window.sv
// ----------------------------------------------------------------------------
// oam_window
// Circular sample window for one axis with a running sum. The sum after the
// current write is offered combinationally for capture downstream.
// ----------------------------------------------------------------------------
module oam_window (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_wr_en,
    input  logic [oam_pkg::SAMPLE_W-1:0]        i_sample,
    output logic [oam_pkg::SUM_W-1:0]           o_sum_next
);
    import oam_pkg::*;

    logic [SAMPLE_W-1:0]      r_mem [WIN_DEPTH];
    logic [WIN_LOG2-1:0]      r_pos;
    logic signed [SUM_W-1:0]  r_sum;
    logic signed [SUM_W-1:0]  n_sum;
    logic signed [SAMPLE_W-1:0] w_old;
    logic signed [SAMPLE_W-1:0] w_new;

    assign w_old = $signed(r_mem[r_pos]);
    assign w_new = $signed(i_sample);

    // drop the entry being overwritten, add the new one
    assign n_sum      = r_sum - SUM_W'(w_old) + SUM_W'(w_new);
    assign o_sum_next = n_sum;

    // window storage, position and sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WIN_DEPTH; i++) begin
                r_mem[i] <= WIN_RESET;
            end
            r_pos <= '0;
            r_sum <= SUM_RESET;
        end else if (i_wr_en) begin
            r_mem[r_pos] <= i_sample;
            r_pos        <= r_pos + 1'b1;
            r_sum        <= n_sum;
        end
    end

endmodule

FILE: rtl/core/oam_mag.sv
// ----------------------------------------------------------------------------
// oam_mag
// Three-stage pipeline: capture window sums, form truncated means and their
// squares, then add the squares into the output register.
// ----------------------------------------------------------------------------
module oam_mag (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oam_pkg::t_sum_req   i_req,
    output logic                o_req_ready,
    output oam_pkg::t_result    o_res,
    input  logic                i_res_ready
);
    import oam_pkg::*;

    logic                            r_a_valid;
    logic [AXES-1:0][SUM_W-1:0]      r_a_sum;
    logic                            r_b_valid;
    logic [AXES-1:0][SAMPLE_W-1:0]   r_b_mean;
    logic [AXES-1:0][MAG_W-1:0]      r_b_sq;
    logic                            r_c_valid;
    logic [AXES-1:0][SAMPLE_W-1:0]   r_c_mean;
    logic [MAG_W-1:0]                r_c_mag;

    logic                            w_a_en;
    logic                            w_b_en;
    logic                            w_c_en;
    logic [AXES-1:0][SAMPLE_W-1:0]   w_mean;
    logic [AXES-1:0][MAG_W-1:0]      w_sq;

    // a stage moves when it is empty or its successor moves
    assign w_c_en      = !r_c_valid || i_res_ready;
    assign w_b_en      = !r_b_valid || w_c_en;
    assign w_a_en      = !r_a_valid || w_b_en;
    assign o_req_ready = w_a_en;

    // mean truncated toward zero, then square
    always_comb begin
        logic signed [SUM_W-1:0]    s;
        logic signed [SUM_W-1:0]    biased;
        logic signed [SUM_W-1:0]    shifted;
        logic signed [SAMPLE_W-1:0] m;
        logic signed [2*SAMPLE_W-1:0] p;
        for (int i = 0; i < AXES; i++) begin
            s       = $signed(r_a_sum[i]);
            biased  = s + (s[SUM_W-1] ? SUM_W'(WIN_DEPTH - 1) : SUM_W'(0));
            shifted = biased >>> WIN_LOG2;
            m       = shifted[SAMPLE_W-1:0];
            p       = m * m;
            w_mean[i] = m;
            w_sq[i]   = MAG_W'($unsigned(p));
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            if (w_a_en) begin
                r_a_valid <= i_req.valid;
            end
            if (w_b_en) begin
                r_b_valid <= r_a_valid;
            end
            if (w_c_en) begin
                r_c_valid <= r_b_valid;
            end
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_a_en && i_req.valid) begin
            r_a_sum <= i_req.sum;
        end
        if (w_b_en && r_a_valid) begin
            r_b_mean <= w_mean;
            r_b_sq   <= w_sq;
        end
        if (w_c_en && r_b_valid) begin
            r_c_mean <= r_b_mean;
            r_c_mag  <= r_b_sq[0] + r_b_sq[1] + r_b_sq[2];
        end
    end

    assign o_res.valid = r_c_valid;
    assign o_res.mean  = r_c_mean;
    assign o_res.mag   = r_c_mag;

endmodule

FILE: bench/accel_offset_average_magnitude_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_offset_average_magnitude_tb
// Self-checking bench for the orientation-corrected boxcar filter. Samples go
// in on the slave stream and results come back on the master stream. Each
// accepted sample is run through a local filter model that keeps its own
// windows and threshold. Every result is then compared field by field with
// the oldest prediction. The run covers directed corner samples, several
// threshold settings and three idling mixes, plus a long output hold-off in
// each phase that backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module accel_offset_average_magnitude_tb;
    import oam_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 140;
    localparam int HOLD_CYCLES  = 100;
    localparam int SETTLE       = 8;
    localparam int THR_MAX      = (1 << THR_W) - 1;

    // one predicted filter output
    typedef struct {
        logic signed [SAMPLE_W-1:0] mean_x;
        logic signed [SAMPLE_W-1:0] mean_y;
        logic signed [SAMPLE_W-1:0] mean_z;
        logic [MAG_W-1:0]           mag_sq;
    } t_filtered;

    // ------------------------------------------------------------------------
    // Filter model and result checker
    // ------------------------------------------------------------------------
    class filter_scoreboard;
        logic signed [SAMPLE_W-1:0] hist_x[WIN_DEPTH];
        logic signed [SAMPLE_W-1:0] hist_y[WIN_DEPTH];
        logic signed [SAMPLE_W-1:0] hist_z[WIN_DEPTH];
        int unsigned                wr_slot;
        logic [THR_W-1:0]           threshold;
        t_filtered                  expected_q[$];
        int                         errors;
        int                         samples;
        int                         results;
        int                         ori_hits[6];

        function new();
            for (int i = 0; i < WIN_DEPTH; i++) begin
                hist_x[i] = 16'sd9310;
                hist_y[i] = 16'sd9310;
                hist_z[i] = 16'sd9310;
            end
            wr_slot   = 0;
            threshold = 15'd16000;
            errors    = 0;
            samples   = 0;
            results   = 0;
            foreach (ori_hits[i]) ori_hits[i] = 0;
        endfunction

        function void set_threshold(logic [THR_W-1:0] thr);
            threshold = thr;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // strict compare, priority x+, x-, y+, y-, z+
        function logic [2:0] orientation(int ax, int ay, int az);
            int thr;
            thr = int'(threshold);
            if (ax > thr)       return ORI_XPOS;
            else if (ax < -thr) return ORI_XNEG;
            else if (ay > thr)  return ORI_YPOS;
            else if (ay < -thr) return ORI_YNEG;
            else if (az > thr)  return ORI_ZPOS;
            return ORI_NONE;
        endfunction

        // accepted sample: correct, store in the windows, predict the output
        function void note_sample(logic signed [SAMPLE_W-1:0] ax,
                                  logic signed [SAMPLE_W-1:0] ay,
                                  logic signed [SAMPLE_W-1:0] az);
            logic [2:0] ori;
            int         ox, oy, oz;
            int         sx, sy, sz;
            longint     mag;
            t_filtered  res;
            ori = orientation(ax, ay, az);
            ox = 0; oy = 0; oz = 0;
            case (ori)
                ORI_XPOS: begin ox = 100;  oy = -70;  oz = -500; end
                ORI_XNEG: begin ox = 100;  oy = 0;    oz = 300;  end
                ORI_YPOS: begin ox = 500;  oy = -200; oz = 600;  end
                ORI_YNEG: begin ox = -65;  oy = 0;    oz = -225; end
                ORI_ZPOS: begin ox = 150;  oy = -110; oz = 0;    end
                default:  begin ox = 0;    oy = 0;    oz = 0;    end
            endcase
            ori_hits[ori]++;
            // corrected sample wraps at 16 bits
            hist_x[wr_slot] = SAMPLE_W'(int'(ax) + ox);
            hist_y[wr_slot] = SAMPLE_W'(int'(ay) + oy);
            hist_z[wr_slot] = SAMPLE_W'(int'(az) + oz);
            wr_slot = (wr_slot + 1) % WIN_DEPTH;
            sx = 0; sy = 0; sz = 0;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                sx += int'(hist_x[i]);
                sy += int'(hist_y[i]);
                sz += int'(hist_z[i]);
            end
            // int division truncates toward zero
            res.mean_x = SAMPLE_W'(sx / WIN_DEPTH);
            res.mean_y = SAMPLE_W'(sy / WIN_DEPTH);
            res.mean_z = SAMPLE_W'(sz / WIN_DEPTH);
            mag = longint'(res.mean_x) * res.mean_x + longint'(res.mean_y) * res.mean_y
                + longint'(res.mean_z) * res.mean_z;
            res.mag_sq = mag[MAG_W-1:0];
            expected_q.push_back(res);
            samples++;
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            t_filtered exp_res;
            logic signed [SAMPLE_W-1:0] fx, fy, fz;
            logic [MAG_W-1:0]           mag;
            fx  = data[SAMPLE_W-1:0];
            fy  = data[2*SAMPLE_W-1:SAMPLE_W];
            fz  = data[3*SAMPLE_W-1:2*SAMPLE_W];
            mag = data[3*SAMPLE_W+MAG_W-1:3*SAMPLE_W];
            results++;
            if (expected_q.size() == 0) begin
                $error("unexpected result: x %0d y %0d z %0d mag %0d", fx, fy, fz, mag);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (fx !== exp_res.mean_x) begin
                $error("filtered_x: expected %0d, got %0d", exp_res.mean_x, fx);
                errors++;
            end
            if (fy !== exp_res.mean_y) begin
                $error("filtered_y: expected %0d, got %0d", exp_res.mean_y, fy);
                errors++;
            end
            if (fz !== exp_res.mean_z) begin
                $error("filtered_z: expected %0d, got %0d", exp_res.mean_z, fz);
                errors++;
            end
            if (mag !== exp_res.mag_sq) begin
                $error("magnitude_sq: expected %0d, got %0d", exp_res.mag_sq, mag);
                errors++;
            end
        endfunction

        function void flag_leftovers();
            if (expected_q.size() != 0) begin
                $error("%0d predicted results never arrived", expected_q.size());
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [IN_W-1:0]   i_s_axis_tdata;   // accel_x, accel_y, accel_z
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready;
    logic [OUT_W-1:0]  o_m_axis_tdata;   // filtered_x, _y, _z, magnitude_sq
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [THR_W-1:0]  i_cfg_data;       // tilt_limit

    accel_offset_average_magnitude uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    filter_scoreboard sb = new();

    int tx_idle_pct;
    int rx_idle_pct;
    bit rx_hold_req;
    int holds_done;
    int settings_used;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #(2_000_000 * CLK_PERIOD / 10);
        $display("accel_offset_average_magnitude: mismatch");
        $finish;
    end

    // receiver: random stalls, or a long hold-off on request
    initial begin
        i_m_axis_tready <= 1'b0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                rx_hold_req = 1'b0;
                holds_done++;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tdata);
    end

    // offer one sample, wait for its request to be taken, maybe idle after
    task automatic send_sample(logic [SAMPLE_W-1:0] ax, logic [SAMPLE_W-1:0] ay,
                               logic [SAMPLE_W-1:0] az);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {az, ay, ax};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_sample(ax, ay, az);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    // axis value mixing raw noise, threshold edges, rails and small values
    function automatic logic [SAMPLE_W-1:0] pick_axis(int thr);
        int v;
        case ($urandom_range(0, 9))
            0, 1, 2: v = int'($urandom());
            3, 4, 5: begin
                v = int'($urandom_range(0, 4)) - 2;
                v = $urandom_range(0, 1) ? thr + v : -thr + v;
            end
            6, 7: v = $urandom_range(0, 1) ? 32767 - int'($urandom_range(0, 3))
                                            : -32768 + int'($urandom_range(0, 3));
            default: v = int'($urandom_range(0, 511)) - 256;
        endcase
        return SAMPLE_W'(v);
    endfunction

    // let the pipeline empty before touching the threshold
    task automatic wait_drained();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [THR_W-1:0] thr);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= thr;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_threshold(thr);
        settings_used++;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin
        int thr_set[PHASES];
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_data      <= '0;
        rx_hold_req   = 1'b0;
        settings_used = 1;
        tx_idle_pct   = 13;
        rx_idle_pct   = 68;
        thr_set[0] = 0;
        thr_set[1] = THR_MAX;
        thr_set[2] = 16000;
        thr_set[3] = $urandom_range(2, THR_MAX - 1);
        thr_set[4] = 1;
        thr_set[5] = $urandom_range(2, THR_MAX - 1);

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corner samples at the reset threshold
        send_sample(16'sd16001, 16'sd0, 16'sd0);        // x above
        send_sample(16'sd16000, 16'sd0, 16'sd0);        // x at level: none
        send_sample(-16'sd16001, 16'sd0, 16'sd0);       // x below
        send_sample(-16'sd16000, 16'sd16001, 16'sd0);   // y above
        send_sample(16'sd0, -16'sd16001, 16'sd0);       // y below
        send_sample(16'sd0, 16'sd0, 16'sd16001);        // z above
        send_sample(16'sd0, 16'sd0, -16'sd16001);       // z below is no orientation
        send_sample(16'sd20000, 16'sd20000, 16'sd20000); // x wins priority
        send_sample(-16'sd20000, 16'sd20000, 16'sd0);   // x- beats y+
        send_sample(16'sd0, 16'sd20000, 16'sd20000);    // y beats z
        send_sample(16'sd32767, 16'sd32767, 16'sd32767); // x offset wraps
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(16'sd32767, -16'sd32768, -16'sd32768); // y and z wrap low
        send_sample(16'sd16000, 16'sd32767, 16'sd32767); // y+ : z wraps
        send_sample(16'sd0, -16'sd32768, -16'sd32768);  // y- : z wraps
        send_sample(16'sd16000, 16'sd16000, 16'sd32767); // z+
        send_sample(16'sd0, 16'sd0, 16'sd0);

        for (int p = 0; p < PHASES; p++) begin
            if (p == 2) begin
                tx_idle_pct = 68;
                rx_idle_pct = 13;
            end else if (p == 4) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            wait_drained();
            write_threshold(THR_W'(thr_set[p]));

            // strictness at the threshold extremes
            if (p == 0) begin
                send_sample(16'sd0, 16'sd0, 16'sd0);
                send_sample(16'sd1, 16'sd0, 16'sd0);
                send_sample(16'sd0, 16'sd0, -16'sd1);
                send_sample(16'sd0, -16'sd1, 16'sd0);
            end else if (p == 1) begin
                send_sample(16'sd32767, 16'sd32767, 16'sd32767);
                send_sample(-16'sd32767, 16'sd0, 16'sd0);
                send_sample(-16'sd32768, 16'sd0, 16'sd0);
            end

            for (int i = 0; i < PHASE_ITEMS; i++) begin
                if (i == 40)
                    rx_hold_req = 1'b1;
                send_sample(pick_axis(thr_set[p]), pick_axis(thr_set[p]),
                            pick_axis(thr_set[p]));
            end
        end

        wait_drained();
        sb.flag_leftovers();

        $display("run: %0d samples, %0d results, %0d threshold settings, %0d output holds",
                 sb.samples, sb.results, settings_used, holds_done);
        $display("orientations none/x+/x-/y+/y-/z+: %0d/%0d/%0d/%0d/%0d/%0d",
                 sb.ori_hits[ORI_NONE], sb.ori_hits[ORI_XPOS], sb.ori_hits[ORI_XNEG],
                 sb.ori_hits[ORI_YPOS], sb.ori_hits[ORI_YNEG], sb.ori_hits[ORI_ZPOS]);
        if (sb.errors == 0) begin
            $display("accel_offset_average_magnitude: match");
        end else begin
            $display("accel_offset_average_magnitude: mismatch");
        end
        $finish;
    end

endmodule
